// ----- src/dltq_pkg.sv -----
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and constants of the delta-list timer queue
// operation and status codes, field widths and the packed queue entry
// ----------------------------------------------------------------------------
package dltq_pkg;

   localparam int DEF_MAX_TASKS = 8;
   localparam int DEF_TICK_MS   = 10;

   localparam int OP_W      = 2;
   localparam int TASK_W    = 8;
   localparam int MS_W      = 24;
   localparam int TICKS_W   = 24;
   localparam int RUN_W     = 8;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 4;

   localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK     = 2'd1;
   localparam logic [OP_W-1:0] OP_DISPATCH = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;

   localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;

   typedef struct packed {
      logic [TASK_W-1:0]  task_id;
      logic [TICKS_W-1:0] delta;
      logic [TICKS_W-1:0] period;
      logic [RUN_W-1:0]   runs;
   } entry_type;

endpackage

// ----- src/delta_list_task_timer_queue.sv -----
// ----------------------------------------------------------------------------
// delta_list_task_timer_queue: sorted timer queue with relative delays
// one item at a time: req_stall is raised from accept until the result is
// registered; an add runs two divides, one for the delay and one for the
// period; adds walk and shift entries and dispatches move entries forward
// through the registered-read memory, a read state then a compare or write;
// the result becomes valid as the queue turns idle, and S_DONE waits while a previous result is held by rsp_stall
// reset clears control and the entry count; the memory needs no clearing
// ----------------------------------------------------------------------------
module delta_list_task_timer_queue #(
   parameter int MAX_TASKS = dltq_pkg::DEF_MAX_TASKS,
   parameter int TICK_MS   = dltq_pkg::DEF_TICK_MS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dltq_pkg::OP_W-1:0]      req_operation,
   input  logic [dltq_pkg::TASK_W-1:0]    req_task_id,
   input  logic [dltq_pkg::MS_W-1:0]      req_delay_ms,
   input  logic [dltq_pkg::MS_W-1:0]      req_period_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dltq_pkg::TASK_W-1:0]    rsp_run_task,
   output logic                           rsp_fired,
   output logic [dltq_pkg::STAT_W-1:0]    rsp_status,
   output logic [dltq_pkg::CNT_OUT_W-1:0] rsp_task_count
);

   localparam int IW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DIV_DLY  = 4'd1;
   localparam logic [3:0] S_DIV_PER  = 4'd2;
   localparam logic [3:0] S_INS      = 4'd3;
   localparam logic [3:0] S_WALK_RD  = 4'd4;
   localparam logic [3:0] S_WALK_CMP = 4'd5;
   localparam logic [3:0] S_SHIFT_RD = 4'd6;
   localparam logic [3:0] S_SHIFT_WR = 4'd7;
   localparam logic [3:0] S_PUT      = 4'd8;
   localparam logic [3:0] S_HEAD_RD  = 4'd9;
   localparam logic [3:0] S_HEAD_USE = 4'd10;
   localparam logic [3:0] S_REM_RD   = 4'd11;
   localparam logic [3:0] S_REM_WR   = 4'd12;
   localparam logic [3:0] S_DONE     = 4'd13;

   logic [3:0]                         state_ff, state_in;
   logic [dltq_pkg::OP_W-1:0]          op_ff, op_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [IW-1:0]                      pos_ff, pos_in;
   logic [IW-1:0]                      j_ff, j_in;
   logic [dltq_pkg::TICKS_W-1:0]       before_ff, before_in;
   logic [dltq_pkg::TASK_W-1:0]        ins_task_ff, ins_task_in;
   logic [dltq_pkg::TICKS_W-1:0]       ins_delay_ff, ins_delay_in;
   logic [dltq_pkg::TICKS_W-1:0]       ins_period_ff, ins_period_in;
   logic [dltq_pkg::RUN_W-1:0]         ins_runs_ff, ins_runs_in;
   logic [dltq_pkg::MS_W-1:0]          per_ms_ff, per_ms_in;
   logic [dltq_pkg::TASK_W-1:0]        res_task_ff, res_task_in;
   logic                               res_fired_ff, res_fired_in;
   logic [dltq_pkg::STAT_W-1:0]        res_status_ff, res_status_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [dltq_pkg::TASK_W-1:0]        rsp_task_ff, rsp_task_in;
   logic                               rsp_fired_ff, rsp_fired_in;
   logic [dltq_pkg::STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [dltq_pkg::CNT_OUT_W-1:0]     rsp_count_ff, rsp_count_in;

   dltq_pkg::entry_type                entry_mem_ff [MAX_TASKS];
   dltq_pkg::entry_type                rd_q_ff;
   logic [IW-1:0]                      rd_addr;
   logic                               wr_en;
   logic [IW-1:0]                      wr_addr;
   dltq_pkg::entry_type                wr_data;

   logic                               div_start;
   logic [dltq_pkg::MS_W-1:0]          div_dividend;
   logic                               div_done;
   logic [dltq_pkg::MS_W-1:0]          div_quotient;

   logic                               req_take;
   logic [dltq_pkg::TICKS_W:0]         through;
   logic [dltq_pkg::TICKS_W-1:0]       new_delta;
   logic [CW+dltq_pkg::CNT_OUT_W-1:0]  count_wide;

   dltq_div #(
      .TICK_MS (TICK_MS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall      = (state_ff != S_IDLE);
   assign req_take       = req_valid && !req_stall;
   assign through        = {1'b0, before_ff} + {1'b0, rd_q_ff.delta};
   assign new_delta      = ins_delay_ff - before_ff;
   assign count_wide     = (CW + dltq_pkg::CNT_OUT_W)'(count_ff);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_run_task   = rsp_task_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_task_count = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      j_in          = j_ff;
      before_in     = before_ff;
      ins_task_in   = ins_task_ff;
      ins_delay_in  = ins_delay_ff;
      ins_period_in = ins_period_ff;
      ins_runs_in   = ins_runs_ff;
      per_ms_in     = per_ms_ff;
      res_task_in   = res_task_ff;
      res_fired_in  = res_fired_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_task_in   = rsp_task_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = rd_q_ff;
      div_start     = 1'b0;
      div_dividend  = req_delay_ms;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in         = req_operation;
               res_task_in   = '0;
               res_fired_in  = 1'b0;
               res_status_in = dltq_pkg::STAT_OK;
               case (req_operation)
                  dltq_pkg::OP_ADD: begin
                     if (count_ff >= CW'(MAX_TASKS)) begin
                        res_status_in = dltq_pkg::STAT_FULL;
                        state_in      = S_DONE;
                     end else begin
                        div_start    = 1'b1;
                        div_dividend = req_delay_ms;
                        per_ms_in    = req_period_ms;
                        ins_task_in  = req_task_id;
                        ins_runs_in  = '0;
                        state_in     = S_DIV_DLY;
                     end
                  end
                  dltq_pkg::OP_TICK: begin
                     state_in = (count_ff == '0) ? S_DONE : S_HEAD_RD;
                  end
                  dltq_pkg::OP_DISPATCH: begin
                     if (count_ff == '0) begin
                        res_status_in = dltq_pkg::STAT_NONE;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_HEAD_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_DIV_DLY: begin
            if (div_done) begin
               ins_delay_in = div_quotient;
               div_start    = 1'b1;
               div_dividend = per_ms_ff;
               state_in     = S_DIV_PER;
            end
         end
         S_DIV_PER: begin
            if (div_done) begin
               ins_period_in = div_quotient;
               state_in      = S_INS;
            end
         end
         S_INS: begin
            pos_in    = '0;
            before_in = '0;
            state_in  = (count_ff == '0) ? S_PUT : S_WALK_RD;
         end
         S_WALK_RD: begin
            rd_addr  = pos_ff;
            state_in = S_WALK_CMP;
         end
         S_WALK_CMP: begin
            if ({1'b0, ins_delay_ff} <= through) begin
               j_in     = IW'(count_ff);
               state_in = S_SHIFT_RD;
            end else begin
               before_in = through[dltq_pkg::TICKS_W-1:0];
               pos_in    = pos_ff + IW'(1);
               if ((CW'(pos_ff) + CW'(1)) == count_ff) begin
                  state_in = S_PUT;
               end else begin
                  state_in = S_WALK_RD;
               end
            end
         end
         S_SHIFT_RD: begin
            rd_addr  = j_ff - IW'(1);
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = rd_q_ff;
            if ((j_ff - IW'(1)) == pos_ff) begin
               wr_data.delta = rd_q_ff.delta - new_delta;
               state_in      = S_PUT;
            end else begin
               j_in     = j_ff - IW'(1);
               state_in = S_SHIFT_RD;
            end
         end
         S_PUT: begin
            wr_en           = 1'b1;
            wr_addr         = pos_ff;
            wr_data.task_id = ins_task_ff;
            wr_data.delta   = new_delta;
            wr_data.period  = ins_period_ff;
            wr_data.runs    = ins_runs_ff;
            count_in        = count_ff + CW'(1);
            state_in        = S_DONE;
         end
         S_HEAD_RD: begin
            rd_addr  = '0;
            state_in = S_HEAD_USE;
         end
         S_HEAD_USE: begin
            if (op_ff == dltq_pkg::OP_TICK) begin
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_data = rd_q_ff;
               if (rd_q_ff.delta == '0) begin
                  if (rd_q_ff.runs != dltq_pkg::RUN_MAX) begin
                     wr_data.runs = rd_q_ff.runs + dltq_pkg::RUN_W'(1);
                  end
                  if (rd_q_ff.period != '0) begin
                     wr_data.delta = rd_q_ff.period;
                  end
               end else begin
                  wr_data.delta = rd_q_ff.delta - dltq_pkg::TICKS_W'(1);
               end
               state_in = S_DONE;
            end else if (rd_q_ff.runs == '0) begin
               res_status_in = dltq_pkg::STAT_NONE;
               state_in      = S_DONE;
            end else begin
               res_task_in   = rd_q_ff.task_id;
               res_fired_in  = 1'b1;
               ins_task_in   = rd_q_ff.task_id;
               ins_delay_in  = rd_q_ff.delta;
               ins_period_in = rd_q_ff.period;
               ins_runs_in   = rd_q_ff.runs - dltq_pkg::RUN_W'(1);
               if (count_ff > CW'(1)) begin
                  j_in     = '0;
                  state_in = S_REM_RD;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = (rd_q_ff.period != '0) ? S_INS : S_DONE;
               end
            end
         end
         S_REM_RD: begin
            rd_addr  = j_ff + IW'(1);
            state_in = S_REM_WR;
         end
         S_REM_WR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = rd_q_ff;
            j_in    = j_ff + IW'(1);
            if ((CW'(j_ff) + CW'(2)) == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = (ins_period_ff != '0) ? S_INS : S_DONE;
            end else begin
               state_in = S_REM_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_task_in   = res_task_ff;
               rsp_fired_in  = res_fired_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_wide[dltq_pkg::CNT_OUT_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_q_ff <= entry_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      j_ff          <= j_in;
      before_ff     <= before_in;
      ins_task_ff   <= ins_task_in;
      ins_delay_ff  <= ins_delay_in;
      ins_period_ff <= ins_period_in;
      ins_runs_ff   <= ins_runs_in;
      per_ms_ff     <= per_ms_in;
      res_task_ff   <= res_task_in;
      res_fired_ff  <= res_fired_in;
      res_status_ff <= res_status_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

// ----- src/dltq_div.sv -----
// ----------------------------------------------------------------------------
// dltq_div: milliseconds to ticks converter
// divides by a constant through a reciprocal multiply, a back multiply and
// one correction step on a single shared multiplier
// ----------------------------------------------------------------------------
module dltq_div #(
   parameter int TICK_MS = dltq_pkg::DEF_TICK_MS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [dltq_pkg::MS_W-1:0] dividend,
   output logic                      done,
   output logic [dltq_pkg::MS_W-1:0] quotient
);

   localparam int SHIFT = dltq_pkg::MS_W + $clog2(TICK_MS);
   localparam int MW    = dltq_pkg::MS_W + 2;
   localparam int PW    = dltq_pkg::MS_W + MW;
   localparam logic [MW-1:0] RECIP   = MW'((64'd1 << SHIFT) / TICK_MS);
   localparam logic [MW-1:0] DIVISOR = MW'(TICK_MS);

   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_MUL1 = 2'd1;
   localparam logic [1:0] P_MUL2 = 2'd2;
   localparam logic [1:0] P_FIX  = 2'd3;

   logic [1:0]                phase_ff, phase_in;
   logic [dltq_pkg::MS_W-1:0] x_ff, x_in;
   logic [dltq_pkg::MS_W-1:0] q_ff, q_in;
   logic [PW-1:0]             prod_ff, prod_in;

   logic [dltq_pkg::MS_W-1:0] q_est;
   logic [dltq_pkg::MS_W-1:0] mul_a;
   logic [MW-1:0]             mul_b;
   logic [PW-1:0]             product;
   logic [dltq_pkg::MS_W-1:0] remainder;
   logic                      corr;

   assign q_est     = dltq_pkg::MS_W'(prod_ff >> SHIFT);
   assign mul_a     = (phase_ff == P_MUL1) ? x_ff : q_est;
   assign mul_b     = (phase_ff == P_MUL1) ? RECIP : DIVISOR;
   assign product   = {{MW{1'b0}}, mul_a} * {{dltq_pkg::MS_W{1'b0}}, mul_b};
   assign remainder = x_ff - prod_ff[dltq_pkg::MS_W-1:0];
   assign corr      = ({{(MW - dltq_pkg::MS_W){1'b0}}, remainder} >= DIVISOR);
   assign quotient  = q_ff + dltq_pkg::MS_W'(corr);
   assign done      = (phase_ff == P_FIX);

   always_comb begin
      phase_in = phase_ff;
      x_in     = x_ff;
      q_in     = q_ff;
      prod_in  = prod_ff;
      case (phase_ff)
         P_MUL1: begin
            prod_in  = product;
            phase_in = P_MUL2;
         end
         P_MUL2: begin
            q_in     = q_est;
            prod_in  = product;
            phase_in = P_FIX;
         end
         P_FIX: begin
            phase_in = P_IDLE;
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
      if (start) begin
         x_in     = dividend;
         phase_in = P_MUL1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      x_ff    <= x_in;
      q_ff    <= q_in;
      prod_ff <= prod_in;
   end

endmodule

// ----- src/dltq_checker.sv -----
// ----------------------------------------------------------------------------
// dltq_checker: port-level checks of the delta-list timer queue
// result consistency between fired, run task, status and count, and the
// input held off while an item is in progress
// ----------------------------------------------------------------------------
module dltq_checker #(
   parameter int MAX_TASKS = dltq_pkg::DEF_MAX_TASKS
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [dltq_pkg::TASK_W-1:0]    rsp_run_task,
   input logic                           rsp_fired,
   input logic [dltq_pkg::STAT_W-1:0]    rsp_status,
   input logic [dltq_pkg::CNT_OUT_W-1:0] rsp_task_count
);

   // dispatched item always reports ok
   a_fired_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_status == dltq_pkg::STAT_OK)
      else $error("fired item with non-ok status");

   // no task id without a dispatch
   a_idle_task_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_run_task == '0)
      else $error("run task nonzero without fire");

   // rejected add only when the queue is full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dltq_pkg::STAT_FULL)
         |-> rsp_task_count == dltq_pkg::CNT_OUT_W'(MAX_TASKS))
      else $error("full status with queue not full");

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid
         && $stable(rsp_run_task) && $stable(rsp_fired)
         && $stable(rsp_status) && $stable(rsp_task_count))
      else $error("stalled item changed");

   // accepted item blocks the input on the next cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while busy");

endmodule

bind delta_list_task_timer_queue dltq_checker #(
   .MAX_TASKS (MAX_TASKS)
) u_dltq_checker (.*);

// ----- dv/timer_queue_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_queue_checker: result checker for the delta-list timer queue
// watches both channels, keeps its own copy of the sorted task queue,
// predicts the reply of every accepted item and compares each accepted
// reply, field by field, with the oldest prediction still outstanding
// ----------------------------------------------------------------------------
module timer_queue_checker #(
   parameter int MAX_TASKS = dltq_pkg::DEF_MAX_TASKS,
   parameter int TICK_MS   = dltq_pkg::DEF_TICK_MS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [dltq_pkg::OP_W-1:0]      req_operation,
   input  logic [dltq_pkg::TASK_W-1:0]    req_task_id,
   input  logic [dltq_pkg::MS_W-1:0]      req_delay_ms,
   input  logic [dltq_pkg::MS_W-1:0]      req_period_ms,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [dltq_pkg::TASK_W-1:0]    rsp_run_task,
   input  logic                           rsp_fired,
   input  logic [dltq_pkg::STAT_W-1:0]    rsp_status,
   input  logic [dltq_pkg::CNT_OUT_W-1:0] rsp_task_count,
   output int                             fail_count,
   output int                             outstanding
);

   typedef struct packed {
      logic [dltq_pkg::TASK_W-1:0]    run_task;
      logic                           fired;
      logic [dltq_pkg::STAT_W-1:0]    status;
      logic [dltq_pkg::CNT_OUT_W-1:0] task_count;
   } timer_reply_type;

   dltq_pkg::entry_type slot [MAX_TASKS];
   int unsigned         slot_count;
   timer_reply_type     pending_replies [$];

   // walk the running sum, new entry goes ahead of equal due times
   function automatic void place_task(input logic [dltq_pkg::TASK_W-1:0] id,
                                      input int unsigned due, input int unsigned period,
                                      input logic [dltq_pkg::RUN_W-1:0] runs);
      int unsigned pos;
      int unsigned ahead;
      int unsigned upto;
      int unsigned gap;
      int          j;
      pos   = 0;
      ahead = 0;
      while (pos < slot_count) begin
         upto = ahead + 32'(slot[pos].delta);
         if (due <= upto)
            break;
         ahead = upto;
         pos++;
      end
      gap = due - ahead;
      if (pos < slot_count) begin
         for (j = slot_count; j > pos; j--)
            slot[j] = slot[j-1];
         slot[pos+1].delta = slot[pos+1].delta - gap[dltq_pkg::TICKS_W-1:0];
      end
      slot[pos].task_id = id;
      slot[pos].delta   = gap[dltq_pkg::TICKS_W-1:0];
      slot[pos].period  = period[dltq_pkg::TICKS_W-1:0];
      slot[pos].runs    = runs;
      slot_count++;
   endfunction

   function automatic timer_reply_type schedule_step(input logic [dltq_pkg::OP_W-1:0] op,
                                                     input logic [dltq_pkg::TASK_W-1:0] id,
                                                     input logic [dltq_pkg::MS_W-1:0] delay_ms,
                                                     input logic [dltq_pkg::MS_W-1:0] period_ms);
      timer_reply_type     reply;
      dltq_pkg::entry_type head;
      int                  i;
      reply        = '0;
      reply.status = dltq_pkg::STAT_OK;
      case (op)
         dltq_pkg::OP_ADD: begin
            if (slot_count >= MAX_TASKS)
               reply.status = dltq_pkg::STAT_FULL;
            else
               place_task(id, int'(delay_ms) / TICK_MS, int'(period_ms) / TICK_MS, '0);
         end
         dltq_pkg::OP_TICK: begin
            if (slot_count > 0) begin
               if (slot[0].delta == 0) begin
                  if (slot[0].runs != dltq_pkg::RUN_MAX)
                     slot[0].runs = slot[0].runs + 1'b1;
                  if (slot[0].period != 0)
                     slot[0].delta = slot[0].period;
               end else begin
                  slot[0].delta = slot[0].delta - 1'b1;
               end
            end
         end
         dltq_pkg::OP_DISPATCH: begin
            if (slot_count == 0 || slot[0].runs == 0) begin
               reply.status = dltq_pkg::STAT_NONE;
            end else begin
               head           = slot[0];
               reply.run_task = head.task_id;
               reply.fired    = 1'b1;
               for (i = 0; i + 1 < slot_count; i++)
                  slot[i] = slot[i+1];
               slot[slot_count-1] = '0;
               slot_count--;
               if (head.period != 0)
                  place_task(head.task_id, 32'(head.delta), 32'(head.period),
                             head.runs - 1'b1);
            end
         end
         default: begin
         end
      endcase
      reply.task_count = slot_count[dltq_pkg::CNT_OUT_W-1:0];
      return reply;
   endfunction

   task automatic flag_mismatch(input string why, input timer_reply_type want,
                                input timer_reply_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s: expected task %0d fired %0d status %0d count %0d",
                  $time, why, want.run_task, want.fired, want.status, want.task_count);
         $display("%0t: %s: got task %0d fired %0d status %0d count %0d",
                  $time, why, got.run_task, got.fired, got.status, got.task_count);
      end
   endtask

   always @(posedge clock) begin : watch
      timer_reply_type got;
      timer_reply_type want;
      if (reset) begin
         for (int k = 0; k < MAX_TASKS; k++)
            slot[k] = '0;
         slot_count = 0;
         pending_replies.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_run_task, rsp_fired, rsp_status, rsp_task_count};
            if (pending_replies.size() == 0) begin
               flag_mismatch("reply with no item outstanding", '0, got);
            end else begin
               want = pending_replies.pop_front();
               if (got.run_task !== want.run_task || got.fired !== want.fired ||
                   got.status !== want.status || got.task_count !== want.task_count)
                  flag_mismatch("reply mismatch", want, got);
            end
         end
         if (req_valid && !req_stall)
            pending_replies.push_back(schedule_step(req_operation, req_task_id,
                                                    req_delay_ms, req_period_ms));
         outstanding <= pending_replies.size();
      end
   end

endmodule

// ----- dv/tb_delta_list_task_timer_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_list_task_timer_queue: testbench of the delta-list timer queue
// directed items cover empty queue, extreme fields, equal due times, a full
// queue and run count saturation; random add/tick/dispatch sequences follow,
// with bursty input, a patterned output stall and one long output hold-off
// ----------------------------------------------------------------------------
module tb_delta_list_task_timer_queue;

   localparam logic [dltq_pkg::OP_W-1:0] OP_UNUSED    = 2'd3;
   localparam int                        HOLD_CYCLES  = 400;
   localparam int                        RANDOM_ITEMS = 200;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [dltq_pkg::OP_W-1:0]      req_operation = dltq_pkg::OP_TICK;
   logic [dltq_pkg::TASK_W-1:0]    req_task_id = '0;
   logic [dltq_pkg::MS_W-1:0]      req_delay_ms = '0;
   logic [dltq_pkg::MS_W-1:0]      req_period_ms = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [dltq_pkg::TASK_W-1:0]    rsp_run_task;
   logic                           rsp_fired;
   logic [dltq_pkg::STAT_W-1:0]    rsp_status;
   logic [dltq_pkg::CNT_OUT_W-1:0] rsp_task_count;
   int                             fail_count;
   int                             outstanding;
   int                             burst_left = 0;
   int                             issued = 0;

   always #2 clock = ~clock;

   delta_list_task_timer_queue i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_task_id    (req_task_id),
      .req_delay_ms   (req_delay_ms),
      .req_period_ms  (req_period_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_run_task   (rsp_run_task),
      .rsp_fired      (rsp_fired),
      .rsp_status     (rsp_status),
      .rsp_task_count (rsp_task_count)
   );

   timer_queue_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_task_id    (req_task_id),
      .req_delay_ms   (req_delay_ms),
      .req_period_ms  (req_period_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_run_task   (rsp_run_task),
      .rsp_fired      (rsp_fired),
      .rsp_status     (rsp_status),
      .rsp_task_count (rsp_task_count),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   function automatic logic [dltq_pkg::MS_W-1:0] any_ms();
      return dltq_pkg::MS_W'($urandom_range(0, 24'hFFFFFF));
   endfunction

   function automatic logic [dltq_pkg::TASK_W-1:0] any_id();
      return dltq_pkg::TASK_W'($urandom_range(0, 255));
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic [dltq_pkg::OP_W-1:0] op,
                            input logic [dltq_pkg::TASK_W-1:0] id,
                            input logic [dltq_pkg::MS_W-1:0] delay_ms,
                            input logic [dltq_pkg::MS_W-1:0] period_ms);
      if (burst_left == 0) begin
         if ($urandom_range(0, 2) != 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_valid     = 1'b1;
      req_operation = op;
      req_task_id   = id;
      req_delay_ms  = delay_ms;
      req_period_ms = period_ms;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      burst_left--;
      if (op != OP_UNUSED)
         issued++;
      @(negedge clock);
   endtask

   // output side stall pattern, with one long hold-off
   initial begin : drain_side
      int stall_mode;
      int seg_len;
      int cycles;
      bit held;
      cycles = 0;
      held   = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall_mode = $urandom_range(0, 2);
         seg_len    = $urandom_range(10, 150);
         repeat (seg_len) begin
            case (stall_mode)
               0:       rsp_stall = 1'b0;
               1:       rsp_stall = 1'($urandom_range(0, 1));
               default: rsp_stall = ($urandom_range(0, 7) != 0);
            endcase
            @(negedge clock);
            cycles++;
         end
         if (!held && cycles >= 2000) begin
            held      = 1'b1;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
      end
   end

   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int waited;
      int pick;
      logic [dltq_pkg::MS_W-1:0] period_ms;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send_item(dltq_pkg::OP_DISPATCH, any_id(), any_ms(), any_ms());
      send_item(dltq_pkg::OP_TICK, any_id(), any_ms(), any_ms());
      send_item(OP_UNUSED, any_id(), any_ms(), any_ms());
      send_item(dltq_pkg::OP_ADD, 8'h00, 24'd0, 24'd0);
      send_item(dltq_pkg::OP_ADD, 8'hFF, 24'hFFFFFF, 24'hFFFFFF);
      send_item(dltq_pkg::OP_ADD, 8'h5A, 24'd30, 24'd20);
      send_item(dltq_pkg::OP_ADD, 8'hA5, 24'd39, 24'd0);
      send_item(dltq_pkg::OP_DISPATCH, any_id(), any_ms(), any_ms());
      send_item(dltq_pkg::OP_TICK, any_id(), any_ms(), any_ms());
      send_item(dltq_pkg::OP_DISPATCH, any_id(), any_ms(), any_ms());
      send_item(dltq_pkg::OP_ADD, 8'h11, 24'd10, 24'd0);
      send_item(dltq_pkg::OP_ADD, 8'h22, 24'd20, 24'd10);
      send_item(dltq_pkg::OP_ADD, 8'h33, 24'd29, 24'd9);
      send_item(dltq_pkg::OP_ADD, 8'h44, 24'd40, 24'd50);
      send_item(dltq_pkg::OP_ADD, 8'h55, 24'd50, 24'd0);
      send_item(dltq_pkg::OP_ADD, 8'h66, 24'd5, 24'd5);
      // run count saturation on a due one-shot head
      repeat (270)
         send_item(dltq_pkg::OP_TICK, any_id(), any_ms(), any_ms());
      repeat (3)
         send_item(dltq_pkg::OP_DISPATCH, any_id(), any_ms(), any_ms());

      // random
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            period_ms = ($urandom_range(0, 3) == 0) ?
                        dltq_pkg::MS_W'($urandom_range(1, 80)) : '0;
            send_item(dltq_pkg::OP_ADD, any_id(), dltq_pkg::MS_W'($urandom_range(0, 60)),
                      period_ms);
            repeat ($urandom_range(0, 6))
               send_item(dltq_pkg::OP_TICK, any_id(), any_ms(), any_ms());
            repeat ($urandom_range(1, 2))
               send_item(dltq_pkg::OP_DISPATCH, any_id(), any_ms(), any_ms());
         end else begin
            pick = $urandom_range(0, 2);
            send_item(dltq_pkg::OP_W'($urandom_range(0, 3)), any_id(),
                      (pick == 0) ? any_ms() : dltq_pkg::MS_W'($urandom_range(0, 100)),
                      (pick == 0) ? any_ms() : dltq_pkg::MS_W'($urandom_range(0, 100)));
         end
      end
      req_valid = 1'b0;

      waited = 0;
      while (outstanding != 0 && waited < 50000) begin
         @(negedge clock);
         waited++;
      end
      repeat (100) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
